@@ sv/pmt_pkg.sv @@
package pmt_pkg;

   localparam int MAX_SCREEN  = 4096;
   localparam int BOUND_LIMIT = (MAX_SCREEN < 4096) ? MAX_SCREEN : 4096;
   localparam logic [12:0] BOUND_MAX = 13'(BOUND_LIMIT);
   localparam logic [12:0] BOUND_MIN = 13'd1;

   localparam logic [1:0] KIND_BYTE    = 2'd0;
   localparam logic [1:0] KIND_MOVE    = 2'd1;
   localparam logic [1:0] KIND_INSTALL = 2'd2;

   localparam logic [1:0] CSR_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_SENS   = 2'd2;

   localparam logic [1:0] SENS_HALF   = 2'd0;
   localparam logic [1:0] SENS_NORMAL = 2'd1;

   localparam logic [12:0] WIDTH_RESET  = 13'd640;
   localparam logic [12:0] HEIGHT_RESET = 13'd480;

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_MOVE,
      OP_CENTER
   } op_type;

   typedef struct packed {
      op_type             op;
      logic signed [12:0] dx;
      logic signed [12:0] dy;
      logic [4:0]         buttons;
      logic               installed;
   } cmd_type;

   function automatic logic [12:0] eff_bound(logic [12:0] size);
      logic [12:0] b;
      if (size < BOUND_MIN) begin
         b = BOUND_MIN;
      end else if (size > BOUND_MAX) begin
         b = BOUND_MAX;
      end else begin
         b = size;
      end
      return b;
   endfunction

endpackage

@@ sv/pmt_front.sv @@
module pmt_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_kind,
   input  logic [7:0]        req_data_byte,
   input  logic signed [12:0] req_move_x,
   input  logic signed [12:0] req_move_y,
   input  logic [4:0]        req_button_bits,
   input  logic [1:0]        sensitivity,
   input  logic              q_full,
   output logic              q_push,
   output pmt_pkg::cmd_type  q_cmd
);
   import pmt_pkg::*;

   logic [1:0] byte_index_ff, byte_index_in;
   logic [7:0] header_ff, header_in;
   logic [7:0] delta_x_ff, delta_x_in;
   logic       tracking_ff, tracking_in;
   logic       accept;
   cmd_type    cmd;

   function automatic logic signed [12:0] accel(logic signed [8:0] d, logic [1:0] sens);
      logic [8:0]         mag;
      logic [1:0]         sh;
      logic signed [12:0] ext;
      mag = d[8] ? 9'(-d) : 9'(d);
      if (mag >= 9'd6) begin
         sh = 2'd2;
      end else if (mag >= 9'd3) begin
         sh = 2'd1;
      end else begin
         sh = 2'd0;
      end
      if (sens == SENS_HALF) begin
         sh = (sh == 2'd0) ? 2'd0 : sh - 2'd1;
      end else if (sens != SENS_NORMAL) begin
         sh = sh + 2'd1;
      end
      ext = {{4{d[8]}}, d};
      return ext <<< sh;
   endfunction

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign q_push    = accept;
   assign q_cmd     = cmd;

   always_comb begin
      byte_index_in = byte_index_ff;
      header_in     = header_ff;
      delta_x_in    = delta_x_ff;
      tracking_in   = tracking_ff;
      cmd.op        = OP_HOLD;
      cmd.dx        = '0;
      cmd.dy        = '0;
      cmd.buttons   = '0;
      case (req_kind)
         KIND_BYTE: begin
            if (tracking_ff) begin
               case (byte_index_ff)
                  2'd0: begin
                     if (req_data_byte[3]) begin
                        header_in     = req_data_byte;
                        byte_index_in = 2'd1;
                     end
                  end
                  2'd1: begin
                     delta_x_in    = req_data_byte;
                     byte_index_in = 2'd2;
                  end
                  default: begin
                     byte_index_in = 2'd0;
                     if (header_ff[7:6] == 2'b00) begin
                        cmd.op      = OP_MOVE;
                        cmd.dx      = accel({header_ff[4], delta_x_ff}, sensitivity);
                        cmd.dy      = -accel({header_ff[5], req_data_byte}, sensitivity);
                        cmd.buttons = {2'b00, header_ff[2:0]};
                     end
                  end
               endcase
            end
         end
         KIND_MOVE: begin
            cmd.op      = OP_MOVE;
            cmd.dx      = req_move_x;
            cmd.dy      = req_move_y;
            cmd.buttons = req_button_bits;
            tracking_in = 1'b1;
         end
         KIND_INSTALL: begin
            cmd.op        = OP_CENTER;
            byte_index_in = 2'd0;
            tracking_in   = 1'b1;
         end
         default: begin
            cmd.op = OP_HOLD;
         end
      endcase
      cmd.installed = tracking_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff <= '0;
         header_ff     <= '0;
         delta_x_ff    <= '0;
         tracking_ff   <= 1'b0;
      end else if (accept) begin
         byte_index_ff <= byte_index_in;
         header_ff     <= header_in;
         delta_x_ff    <= delta_x_in;
         tracking_ff   <= tracking_in;
      end
   end

endmodule

@@ sv/pmt_queue.sv @@
module pmt_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  pmt_pkg::cmd_type push_cmd,
   output logic             full,
   output logic             head_valid,
   output pmt_pkg::cmd_type head_cmd,
   input  logic             pop
);
   import pmt_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              do_push;
   logic              do_pop;

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   function automatic logic [PTR_W-1:0] next_ptr(logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (do_pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

endmodule

@@ sv/pmt_back.sv @@
module pmt_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  pmt_pkg::cmd_type head_cmd,
   output logic             pop,
   input  logic [12:0]      bound_x,
   input  logic [12:0]      bound_y,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [11:0]      rsp_pos_x,
   output logic [11:0]      rsp_pos_y,
   output logic [4:0]       rsp_buttons,
   output logic             rsp_changed,
   output logic             rsp_installed
);
   import pmt_pkg::*;

   logic [11:0] cursor_x_ff, cursor_x_in;
   logic [11:0] cursor_y_ff, cursor_y_in;
   logic [4:0]  buttons_ff, buttons_in;
   logic        changed_ff, changed_in;
   logic        installed_ff;
   logic        rsp_valid_ff;

   function automatic logic [11:0] clamp(logic [11:0] pos, logic signed [12:0] d,
                                         logic [12:0] bound);
      logic signed [14:0] s;
      logic [11:0]        r;
      s = $signed({3'b000, pos}) + {{2{d[12]}}, d};
      if (s < 0) begin
         r = '0;
      end else if (s >= $signed({2'b00, bound})) begin
         r = 12'(bound - 13'd1);
      end else begin
         r = s[11:0];
      end
      return r;
   endfunction

   assign pop = head_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      cursor_x_in = cursor_x_ff;
      cursor_y_in = cursor_y_ff;
      buttons_in  = buttons_ff;
      changed_in  = 1'b0;
      case (head_cmd.op)
         OP_MOVE: begin
            cursor_x_in = clamp(cursor_x_ff, head_cmd.dx, bound_x);
            cursor_y_in = clamp(cursor_y_ff, head_cmd.dy, bound_y);
            buttons_in  = head_cmd.buttons;
            changed_in  = 1'b1;
         end
         OP_CENTER: begin
            cursor_x_in = bound_x[12:1];
            cursor_y_in = bound_y[12:1];
            buttons_in  = '0;
         end
         default: begin
            changed_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_x_ff  <= '0;
         cursor_y_ff  <= '0;
         buttons_ff   <= '0;
         changed_ff   <= 1'b0;
         installed_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (pop) begin
         cursor_x_ff  <= cursor_x_in;
         cursor_y_ff  <= cursor_y_in;
         buttons_ff   <= buttons_in;
         changed_ff   <= changed_in;
         installed_ff <= head_cmd.installed;
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pos_x     = cursor_x_ff;
   assign rsp_pos_y     = cursor_y_ff;
   assign rsp_buttons   = buttons_ff;
   assign rsp_changed   = changed_ff;
   assign rsp_installed = installed_ff;

endmodule

@@ sv/ps2_mouse_packet_tracker.sv @@
// Channel   Handshake               Payload
// req       req_valid / req_ready   kind, data_byte, move_x, move_y, button_bits
// rsp       rsp_valid / rsp_ready   pos_x, pos_y, buttons, changed, installed
// csr       csr_valid / csr_ready   csr_index, csr_data (always ready)
//
// One transaction per cycle sustained while rsp_ready stays high; the front decodes
// and accelerates in the accept cycle and the queue registers the command, then the
// back clamps and loads the output register when it pops that command.
// A two-entry command queue decouples the sides; req_ready drops only when it is full.
// Synchronous reset clears packet sync, cursor, buttons and the install flag.
module ps2_mouse_packet_tracker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_kind,
   input  logic [7:0]        req_data_byte,
   input  logic signed [12:0] req_move_x,
   input  logic signed [12:0] req_move_y,
   input  logic [4:0]        req_button_bits,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [11:0]       rsp_pos_x,
   output logic [11:0]       rsp_pos_y,
   output logic [4:0]        rsp_buttons,
   output logic              rsp_changed,
   output logic              rsp_installed,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [12:0]       csr_data
);
   import pmt_pkg::*;

   logic [12:0] width_ff;
   logic [12:0] height_ff;
   logic [1:0]  sens_ff;
   logic [12:0] bound_x;
   logic [12:0] bound_y;
   logic        q_full;
   logic        q_push;
   logic        q_head_valid;
   logic        q_pop;
   cmd_type     q_push_cmd;
   cmd_type     q_head_cmd;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         sens_ff   <= SENS_NORMAL;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_WIDTH:  width_ff  <= csr_data;
            CSR_HEIGHT: height_ff <= csr_data;
            CSR_SENS:   sens_ff   <= csr_data[1:0];
            default:    sens_ff   <= sens_ff;
         endcase
      end
   end

   assign bound_x = eff_bound(width_ff);
   assign bound_y = eff_bound(height_ff);

   pmt_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_data_byte   (req_data_byte),
      .req_move_x      (req_move_x),
      .req_move_y      (req_move_y),
      .req_button_bits (req_button_bits),
      .sensitivity     (sens_ff),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_cmd           (q_push_cmd)
   );

   pmt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (q_push_cmd),
      .full       (q_full),
      .head_valid (q_head_valid),
      .head_cmd   (q_head_cmd),
      .pop        (q_pop)
   );

   pmt_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (q_head_valid),
      .head_cmd      (q_head_cmd),
      .pop           (q_pop),
      .bound_x       (bound_x),
      .bound_y       (bound_y),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_pos_x     (rsp_pos_x),
      .rsp_pos_y     (rsp_pos_y),
      .rsp_buttons   (rsp_buttons),
      .rsp_changed   (rsp_changed),
      .rsp_installed (rsp_installed)
   );

`ifndef ASSERT_OFF
   a_changed_x_in_bounds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_changed |-> {1'b0, rsp_pos_x} < bound_x)
      else $error("updated x lies outside the screen");

   a_changed_y_in_bounds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_changed |-> {1'b0, rsp_pos_y} < bound_y)
      else $error("updated y lies outside the screen");

   a_installed_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_installed |=> !rsp_valid || rsp_installed)
      else $error("install flag dropped without reset");

   a_queue_pop_has_data: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_head_valid)
      else $error("back side popped an empty queue");
`endif

endmodule

@@ bench/tb_top.sv @@
module tb_top;
   import pmt_pkg::*;

   localparam logic [1:0] KIND_NONE   = 2'd3;
   localparam logic [1:0] CSR_SPARE   = 2'd3;
   localparam logic [1:0] SENS_DOUBLE = 2'd2;
   localparam int         STALL_LIMIT = 5000;
   localparam int         RANDOM_ITEMS = 1530;

   typedef struct packed {
      logic [11:0] pos_x;
      logic [11:0] pos_y;
      logic [4:0]  buttons;
      logic        changed;
      logic        installed;
   } cursor_view_type;

   logic              clock;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [1:0]        req_kind = KIND_BYTE;
   logic [7:0]        req_data_byte = 8'h00;
   logic signed [12:0] req_move_x = 13'sd0;
   logic signed [12:0] req_move_y = 13'sd0;
   logic [4:0]        req_button_bits = 5'h00;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [11:0]       rsp_pos_x;
   logic [11:0]       rsp_pos_y;
   logic [4:0]        rsp_buttons;
   logic              rsp_changed;
   logic              rsp_installed;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [1:0]        csr_index = CSR_WIDTH;
   logic [12:0]       csr_data = 13'd0;

   ps2_mouse_packet_tracker dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_data_byte  (req_data_byte),
      .req_move_x     (req_move_x),
      .req_move_y     (req_move_y),
      .req_button_bits(req_button_bits),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pos_x      (rsp_pos_x),
      .rsp_pos_y      (rsp_pos_y),
      .rsp_buttons    (rsp_buttons),
      .rsp_changed    (rsp_changed),
      .rsp_installed  (rsp_installed),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // shadow of the tracker
   logic [12:0] width_reg   = WIDTH_RESET;
   logic [12:0] height_reg  = HEIGHT_RESET;
   logic [1:0]  sens_reg    = SENS_NORMAL;
   int          pkt_index   = 0;
   logic [7:0]  pkt_header  = 8'h00;
   logic [7:0]  pkt_dx      = 8'h00;
   logic [11:0] cur_x       = 12'd0;
   logic [11:0] cur_y       = 12'd0;
   logic [4:0]  cur_buttons = 5'd0;
   logic        tracking    = 1'b0;

   cursor_view_type pending_views[$];
   int items_sent     = 0;
   int results_seen   = 0;
   int mismatch_count = 0;
   int send_idle_pct  = 0;
   int recv_idle_pct  = 0;
   int quiet_cycles   = 0;

   function automatic int screen_limit(logic [12:0] size);
      int lim;
      lim = int'(size);
      if (lim < 1) lim = 1;
      if (lim > MAX_SCREEN) lim = MAX_SCREEN;
      if (lim > 4096) lim = 4096;
      return lim;
   endfunction

   function automatic int accel_delta(int d);
      int mag;
      int mult;
      mag = (d < 0) ? -d : d;
      mult = (mag >= 6) ? 4 : ((mag >= 3) ? 2 : 1);
      if (sens_reg == SENS_HALF) begin
         mult = (mult + 1) / 2;
      end else if (sens_reg >= SENS_DOUBLE) begin
         mult = mult * 2;
      end
      return d * mult;
   endfunction

   function automatic logic [11:0] clamp_axis(int p, int lim);
      if (p < 0) p = 0;
      if (p >= lim) p = lim - 1;
      return 12'(p);
   endfunction

   function automatic cursor_view_type track_item(logic [1:0] kind, logic [7:0] data,
                                                logic [12:0] mx, logic [12:0] my,
                                                logic [4:0] btn);
      cursor_view_type v;
      int w;
      int h;
      int dx;
      int dy;
      w = screen_limit(width_reg);
      h = screen_limit(height_reg);
      v.changed = 1'b0;
      case (kind)
         KIND_BYTE: begin
            if (tracking) begin
               if (pkt_index == 0) begin
                  if (data[3]) begin
                     pkt_header = data;
                     pkt_index = 1;
                  end
               end else if (pkt_index == 1) begin
                  pkt_dx = data;
                  pkt_index = 2;
               end else begin
                  pkt_index = 0;
                  if (pkt_header[7:6] == 2'b00) begin
                     dx = int'(pkt_dx) - (pkt_header[4] ? 256 : 0);
                     dy = int'(data) - (pkt_header[5] ? 256 : 0);
                     cur_x = clamp_axis(int'(cur_x) + accel_delta(dx), w);
                     cur_y = clamp_axis(int'(cur_y) - accel_delta(dy), h);
                     cur_buttons = {2'b00, pkt_header[2:0]};
                     v.changed = 1'b1;
                  end
               end
            end
         end
         KIND_MOVE: begin
            cur_x = clamp_axis(int'(cur_x) + int'($signed(mx)), w);
            cur_y = clamp_axis(int'(cur_y) + int'($signed(my)), h);
            cur_buttons = btn;
            v.changed = 1'b1;
            tracking = 1'b1;
         end
         KIND_INSTALL: begin
            cur_x = 12'(w / 2);
            cur_y = 12'(h / 2);
            cur_buttons = 5'd0;
            pkt_index = 0;
            tracking = 1'b1;
         end
         default: begin
         end
      endcase
      v.pos_x = cur_x;
      v.pos_y = cur_y;
      v.buttons = cur_buttons;
      v.installed = tracking;
      return v;
   endfunction

   task automatic check_field(string name, logic [11:0] want, logic [11:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      cursor_view_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_WIDTH:  width_reg = csr_data;
               CSR_HEIGHT: height_reg = csr_data;
               CSR_SENS:   sens_reg = csr_data[1:0];
               default: begin
               end
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_views.size() == 0) begin
               $error("result transaction with nothing pending");
               mismatch_count++;
            end else begin
               want = pending_views.pop_front();
               check_field("pos_x", want.pos_x, rsp_pos_x);
               check_field("pos_y", want.pos_y, rsp_pos_y);
               check_field("buttons", 12'(want.buttons), 12'(rsp_buttons));
               check_field("changed", 12'(want.changed), 12'(rsp_changed));
               check_field("installed", 12'(want.installed), 12'(rsp_installed));
            end
            results_seen++;
         end
         if (req_valid && req_ready) begin
            pending_views.push_back(track_item(req_kind, req_data_byte, req_move_x,
                                               req_move_y, req_button_bits));
         end
      end
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("ps2_mouse_packet_tracker regression: fail");
         $finish;
      end
   end

   task automatic send_item(input logic [1:0] kind, input logic [7:0] data,
                            input logic [12:0] mx, input logic [12:0] my,
                            input logic [4:0] btn);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid       <= 1'b1;
      req_kind        <= kind;
      req_data_byte   <= data;
      req_move_x      <= mx;
      req_move_y      <= my;
      req_button_bits <= btn;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic send_byte(input logic [7:0] b);
      send_item(KIND_BYTE, b, 13'($urandom), 13'($urandom), 5'($urandom));
   endtask

   task automatic send_packet(input logic [7:0] hdr, input logic [7:0] dx,
                              input logic [7:0] dy);
      send_byte(hdr);
      send_byte(dx);
      send_byte(dy);
   endtask

   task automatic send_install();
      send_item(KIND_INSTALL, 8'($urandom), 13'($urandom), 13'($urandom), 5'($urandom));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (results_seen != items_sent) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [12:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic set_screen(input logic [12:0] w, input logic [12:0] h,
                             input logic [12:0] s);
      write_reg(CSR_WIDTH, w);
      write_reg(CSR_HEIGHT, h);
      write_reg(CSR_SENS, s);
      write_reg(CSR_SPARE, 13'($urandom));
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [8:0] rand_delta();
      int d;
      if ($urandom_range(3) == 0) begin
         d = int'($urandom_range(511)) - 256;
      end else begin
         d = int'($urandom_range(16)) - 8;
      end
      return 9'(d);
   endfunction

   function automatic logic [12:0] rand_move();
      if ($urandom_range(4) == 0) return 13'($urandom);
      return 13'(int'($urandom_range(40)) - 20);
   endfunction

   function automatic logic [12:0] rand_size();
      case ($urandom_range(9))
         0: return 13'd0;
         1: return 13'd1;
         2: return 13'd4096;
         3: return 13'h1FFF;
         4: return 13'($urandom_range(8191, 4097));
         default: return 13'($urandom_range(1024, 2));
      endcase
   endfunction

   task automatic test_power_on();
      send_byte(8'h08);
      send_item(KIND_NONE, 8'($urandom), 13'($urandom), 13'($urandom), 5'($urandom));
      send_item(KIND_MOVE, 8'($urandom), 13'h0FFF, 13'h1000, 5'h1F);
      send_install();
   endtask

   task automatic test_packet_cases();
      send_byte(8'h00);
      send_packet(8'h0F, 8'h02, 8'hFE);
      send_packet(8'h38, 8'h00, 8'hFF);
      send_packet(8'h19, 8'hFB, 8'h05);
      send_packet(8'h48, 8'h7F, 8'h7F);
      send_packet(8'hFF, 8'h80, 8'h01);
      send_item(KIND_NONE, 8'hFF, 13'h0FFF, 13'h1000, 5'h1F);
      send_item(KIND_MOVE, 8'h00, 13'h1000, 13'h0FFF, 5'h00);
   endtask

   task automatic test_register_extremes();
      drain();
      set_screen(13'd0, 13'h1FFF, {11'd0, SENS_HALF});
      send_install();
      send_item(KIND_MOVE, 8'h5A, 13'h0FFF, 13'h0FFF, 5'h0A);
      send_packet(8'h08, 8'h07, 8'h03);
      drain();
      // width bound raised, height bound kept at the limit, sensitivity doubled
      set_screen(13'd5, 13'd4096, {11'h7FF, SENS_DOUBLE});
      send_item(KIND_MOVE, 8'hA5, 13'd0, 13'd0, 5'h15);
      send_packet(8'h28, 8'h06, 8'h00);
      drain();
      set_screen(13'd4097, 13'd1, 13'd3);
      send_install();
      send_packet(8'h08, 8'h06, 8'h06);
      drain();
      set_screen(WIDTH_RESET, HEIGHT_RESET, {11'd0, SENS_NORMAL});
   endtask

   task automatic rand_traffic(int count);
      int n;
      int pick;
      logic [8:0] dx;
      logic [8:0] dy;
      logic [1:0] ovf;
      n = 0;
      while (n < count) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            dx = rand_delta();
            dy = rand_delta();
            ovf = ($urandom_range(9) == 0) ? 2'($urandom_range(3, 1)) : 2'b00;
            send_packet({ovf, dy[8], dx[8], 1'b1, 3'($urandom)}, dx[7:0], dy[7:0]);
            n += 3;
         end else if (pick < 82) begin
            send_item(KIND_MOVE, 8'($urandom), rand_move(), rand_move(), 5'($urandom));
            n++;
         end else if (pick < 88) begin
            send_byte(8'($urandom));
            n++;
         end else if (pick < 92) begin
            // truncated packet
            send_byte(8'($urandom) | 8'h08);
            send_byte(8'($urandom));
            n += 2;
         end else if (pick < 96) begin
            send_item(KIND_NONE, 8'($urandom), 13'($urandom), 13'($urandom), 5'($urandom));
            n++;
         end else begin
            send_install();
            n++;
         end
      end
   endtask

   task automatic test_random(int count);
      repeat (4) begin
         drain();
         set_screen(rand_size(), rand_size(),
                    ($urandom_range(1) == 0) ? 13'($urandom_range(3)) : 13'($urandom));
         rand_traffic(count / 4);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 24;
      recv_idle_pct = 77;
      test_power_on();
      test_packet_cases();
      test_register_extremes();
      test_random(RANDOM_ITEMS / 3);
      send_idle_pct = 77;
      recv_idle_pct = 24;
      test_random(RANDOM_ITEMS / 3);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(RANDOM_ITEMS / 3);
      drain();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("ps2_mouse_packet_tracker regression: pass");
      end else begin
         $display("ps2_mouse_packet_tracker regression: fail");
      end
      $finish;
   end

endmodule
